// ----- src/magnetic_field_lut_interpolator_macros.svh -----
// Assertion helpers for the field table interpolator
`ifndef MAGNETIC_FIELD_LUT_INTERPOLATOR_MACROS_SVH
`define MAGNETIC_FIELD_LUT_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define MFLI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mfli_pkg.sv -----
package mfli_pkg;

  localparam int VAL_W  = 32;
  localparam int OPD_W  = 33;
  localparam int PROD_W = 66;
  localparam int WIDE_W = 52;
  localparam int WORD_W = 96;
  localparam int ROW_W  = 3;
  localparam int COL_W  = 3;
  localparam int CFG_W  = 31;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_W-1:0] CFG_ONE = 31'd65536;
  localparam logic [ROW_W-1:0] ROW_LAST = 3'd5;

  // register indexes
  localparam logic [0:0] CFG_IRW = 1'b0;
  localparam logic [0:0] CFG_IGS = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_OPND = 10'b0000000010,
    ST_MUL  = 10'b0000000100,
    ST_POST = 10'b0000001000,
    ST_SP   = 10'b0000010000,
    ST_FR   = 10'b0000100000,
    ST_RD0  = 10'b0001000000,
    ST_RD1  = 10'b0010000000,
    ST_RD2  = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_AXIS = 2'd0,
    PH_LERP = 2'd1,
    PH_TORQ = 2'd2,
    PH_GRAD = 2'd3
  } phase_e;

  typedef struct packed {
    logic                     en;
    logic signed [OPD_W-1:0]  a;
    logic signed [OPD_W-1:0]  b;
  } mul_req_t;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -52'sd2147483648;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext52(input logic signed [VAL_W-1:0] v);
    return {{(WIDE_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

  function automatic logic signed [OPD_W-1:0] ext33(input logic signed [VAL_W-1:0] v);
    return {v[VAL_W-1], v};
  endfunction

  // component k of a packed {bz, by, bx} word
  function automatic logic signed [VAL_W-1:0] comp(input logic [WORD_W-1:0] w,
                                                   input logic [1:0] k);
    logic signed [VAL_W-1:0] r;
    case (k)
      2'd0:    r = w[31:0];
      2'd1:    r = w[63:32];
      default: r = w[95:64];
    endcase
    return r;
  endfunction

  // (k + 1) mod 3
  function automatic logic [1:0] rot3(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

endpackage

// ----- src/mfli_table.sv -----
module mfli_table #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [mfli_pkg::WORD_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [mfli_pkg::WORD_W-1:0]  rdata_o
);

  logic [mfli_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [mfli_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/mfli_mul.sv -----
module mfli_mul (
  input  logic                                clk_i,
  input  mfli_pkg::mul_req_t                  req_i,
  output logic signed [mfli_pkg::PROD_W-1:0]  prod_o
);

  logic signed [mfli_pkg::OPD_W-1:0]  a_q, b_q;
  logic signed [mfli_pkg::PROD_W-1:0] prod_q;

  // operands registered, then the product registered
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    prod_q <= a_q * b_q;
  end

  assign prod_o = prod_q;

endmodule

// ----- src/magnetic_field_lut_interpolator.sv -----
// Field look-up table and actuation matrix generator.
// Input stream: tuser[0] selects a load (0) or a query (1). A load writes
// one grid point (bx, by, bz) of one coil's table and gives no result.
// A query gives position, magnetization and torque mode.
// Output stream: 6 entries per coil, coil 0 first, rows 0 to 5, tlast on
// the final entry of the query.
// Sequence: axis setup first, then for each coil the four corner pair
// reads, every product in the one shared 33x33 multiplier (more of them
// in torque mode), and the hand-over of the rows. Only one item is in
// work at a time; tready is high only when the sequencer is idle.
// A stalled receiver holds the output register and the sequencer waits
// for it; the next coil starts once all six rows are handed over.
// Reset clears the sequencer and sets both registers to 1.0. The table is
// not cleared: a query may only touch grid points already loaded.
// Configuration writes are taken at any time; issue them only while idle.
`include "magnetic_field_lut_interpolator_macros.svh"

module magnetic_field_lut_interpolator #(
  parameter int GRID_POINTS = 16,
  parameter int COIL_COUNT  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coil, grid_index, vec_x, vec_y, vec_z, mag_x, mag_y, mag_z, torque_mode
  input  logic [mfli_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // row, col, value, 2 bits zero
  output logic [mfli_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_addr_i,
  input  logic [mfli_pkg::CFG_W-1:0]          cfg_wdata_i
);

  localparam int CW     = $clog2(GRID_POINTS);
  localparam int GG     = GRID_POINTS * GRID_POINTS;
  localparam int CELLS  = GG * GRID_POINTS;
  localparam int DEPTH  = COIL_COUNT * CELLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int FL_MAX = GRID_POINTS - 2;

  localparam logic signed [39:0] GM1_S   = 40'(GRID_POINTS - 1);
  localparam logic signed [23:0] FLMAX_S = 24'(FL_MAX);
  localparam logic [AW-1:0] OFF_X   = AW'(GG);
  localparam logic [AW-1:0] OFF_Y   = AW'(GRID_POINTS);
  localparam logic [AW-1:0] OFF_Z   = AW'(1);
  localparam logic [AW-1:0] OFF_XYZ = AW'(GG + GRID_POINTS + 1);
  localparam logic [AW-1:0] OFF_YZ  = AW'(GRID_POINTS + 1);
  localparam logic [AW-1:0] OFF_XZ  = AW'(GG + 1);
  localparam logic [AW-1:0] OFF_XY  = AW'(GG + GRID_POINTS);
  localparam logic [AW-1:0] CELLS_A = AW'(CELLS);
  localparam logic [mfli_pkg::COL_W-1:0] COL_LAST = mfli_pkg::COL_W'(COIL_COUNT - 1);

  // ---------------------------------------------------------------- input fields
  logic                            in_req, in_torque;
  logic [2:0]                      in_coil;
  logic [11:0]                     in_gi;
  logic signed [31:0]              in_vec [3];
  logic signed [31:0]              in_mag [3];
  logic                            in_acc, load_ok;

  assign in_req    = s_axis_tuser[0];
  assign in_coil   = s_axis_tdata[2:0];
  assign in_gi     = s_axis_tdata[14:3];
  assign in_vec[0] = s_axis_tdata[46:15];
  assign in_vec[1] = s_axis_tdata[78:47];
  assign in_vec[2] = s_axis_tdata[110:79];
  assign in_mag[0] = s_axis_tdata[142:111];
  assign in_mag[1] = s_axis_tdata[174:143];
  assign in_mag[2] = s_axis_tdata[206:175];
  assign in_torque = s_axis_tdata[207];

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign load_ok = (32'(in_coil) < COIL_COUNT) && (32'(in_gi) < CELLS);

  // ---------------------------------------------------------------- state
  mfli_pkg::state_e  state_q, state_d;
  mfli_pkg::phase_e  ph_q, ph_d;
  logic [1:0]        k_q, k_d, j_q, j_d, sub_q, sub_d;
  logic [mfli_pkg::ROW_W-1:0] row_q, row_d;
  logic [mfli_pkg::COL_W-1:0] coil_q, coil_d;
  logic [AW-1:0]     base_q, base_d, off_q, off_d;

  logic [mfli_pkg::CFG_W-1:0] irw_q, igs_q;

  logic signed [31:0] pos_q [3];
  logic signed [31:0] m_q [3];
  logic signed [31:0] r_q [3];
  logic signed [31:0] b_q [3];
  logic signed [31:0] res_q [6];
  logic               torque_q;
  logic signed [31:0] s_q, ga_q, gg_q, bd_q;
  logic signed [39:0] sp_q;
  logic signed [mfli_pkg::WIDE_W-1:0] acc_q;
  logic [mfli_pkg::WORD_W-1:0] bf_q, bc_q, bi_q, bj_q;

  logic                             out_valid_q, out_valid_d, out_last_q;
  logic [mfli_pkg::ROW_W-1:0]       out_row_q;
  logic [mfli_pkg::COL_W-1:0]       out_col_q;
  logic signed [31:0]               out_val_q;
  logic                             out_free, emit_go;

  // ---------------------------------------------------------------- table
  logic                        tbl_we, tbl_re;
  logic [AW-1:0]               tbl_waddr, tbl_raddr, coff;
  logic [mfli_pkg::WORD_W-1:0] tbl_wdata, tbl_rdata;

  assign tbl_we    = in_acc && (in_req == mfli_pkg::REQ_LOAD) && load_ok;
  assign tbl_waddr = AW'(32'(in_coil) * CELLS + 32'(in_gi));
  assign tbl_wdata = {in_vec[2], in_vec[1], in_vec[0]};
  assign tbl_re    = (state_q == mfli_pkg::ST_RD0) || (state_q == mfli_pkg::ST_RD1);

  // corner A in the first read cycle, corner B in the second
  always_comb begin
    coff = '0;
    if (state_q == mfli_pkg::ST_RD0) begin
      if (ph_q == mfli_pkg::PH_GRAD) begin
        case (j_q)
          2'd0:    coff = OFF_X;
          2'd1:    coff = OFF_Y;
          default: coff = OFF_Z;
        endcase
      end
    end else begin
      if (ph_q == mfli_pkg::PH_GRAD) begin
        case (j_q)
          2'd0:    coff = OFF_YZ;
          2'd1:    coff = OFF_XZ;
          default: coff = OFF_XY;
        endcase
      end else begin
        coff = OFF_XYZ;
      end
    end
  end

  assign tbl_raddr = base_q + off_q + coff;

  mfli_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // ---------------------------------------------------------------- operands
  logic [1:0]         n1, n2, m_idx, b_idx;
  logic signed [31:0] pos_sel, r_sel, m_sel, b_sel;
  logic signed [31:0] bf_k, bc_k, bi_k, bj_k, ga, gb;
  mfli_pkg::mul_req_t mul_req;
  logic signed [mfli_pkg::PROD_W-1:0] prod;

  assign n1    = mfli_pkg::rot3(j_q);
  assign n2    = mfli_pkg::rot3(n1);
  assign m_idx = (ph_q == mfli_pkg::PH_TORQ) ? ((sub_q == 2'd0) ? n1 : n2) : k_q;
  assign b_idx = (sub_q == 2'd0) ? n2 : n1;

  assign pos_sel = pos_q[k_q];
  assign r_sel   = r_q[k_q];
  assign m_sel   = m_q[m_idx];
  assign b_sel   = b_q[b_idx];

  assign bf_k = mfli_pkg::comp(bf_q, k_q);
  assign bc_k = mfli_pkg::comp(bc_q, k_q);
  assign bi_k = mfli_pkg::comp(bi_q, k_q);
  assign bj_k = mfli_pkg::comp(bj_q, k_q);
  assign ga   = mfli_pkg::sat32(mfli_pkg::ext52(bi_k) - mfli_pkg::ext52(bf_k));
  assign gb   = mfli_pkg::sat32(mfli_pkg::ext52(bc_k) - mfli_pkg::ext52(bj_k));

  always_comb begin
    mul_req.en = (state_q == mfli_pkg::ST_OPND);
    mul_req.a  = mfli_pkg::ext33(m_sel);
    mul_req.b  = mfli_pkg::ext33(b_sel);
    case (ph_q)
      mfli_pkg::PH_AXIS: begin
        mul_req.a = mfli_pkg::ext33(pos_sel);
        mul_req.b = {2'b00, irw_q};
      end
      mfli_pkg::PH_LERP: begin
        mul_req.a = mfli_pkg::ext33(mfli_pkg::sat32(
                      mfli_pkg::ext52(bc_k) - mfli_pkg::ext52(bf_k)));
        mul_req.b = mfli_pkg::ext33(r_sel);
      end
      mfli_pkg::PH_TORQ: begin
        mul_req.a = mfli_pkg::ext33(m_sel);
        mul_req.b = mfli_pkg::ext33(b_sel);
      end
      default: begin
        case (sub_q)
          2'd0: begin
            mul_req.a = mfli_pkg::ext33(mfli_pkg::sat32(
                          mfli_pkg::ext52(gb) - mfli_pkg::ext52(ga)));
            mul_req.b = mfli_pkg::ext33(r_sel);
          end
          2'd1: begin
            mul_req.a = mfli_pkg::ext33(gg_q);
            mul_req.b = {2'b00, igs_q};
          end
          default: begin
            mul_req.a = mfli_pkg::ext33(m_sel);
            mul_req.b = mfli_pkg::ext33(bd_q);
          end
        endcase
      end
    endcase
  end

  mfli_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------- post-processing
  logic signed [mfli_pkg::WIDE_W-1:0] p16, acc_n;
  logic signed [31:0]                 p_sat;
  logic signed [23:0]                 flr;
  logic [CW-1:0]                      fl;
  logic signed [39:0]                 rdiff;

  assign p16   = {{2{prod[mfli_pkg::PROD_W-1]}}, prod[mfli_pkg::PROD_W-1:16]};
  assign p_sat = mfli_pkg::sat32(p16);
  assign acc_n = ((k_q == 2'd0) ? '0 : acc_q) + p16;

  assign flr = sp_q[39:16];
  always_comb begin
    if (flr < 24'sd0) begin
      fl = '0;
    end else if (flr > FLMAX_S) begin
      fl = CW'(FL_MAX);
    end else begin
      fl = flr[CW-1:0];
    end
  end
  assign rdiff = sp_q - $signed(40'(fl) << 16);

  assign out_free = !out_valid_q || m_axis_tready;
  assign emit_go  = (state_q == mfli_pkg::ST_EMIT) && out_free;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    k_d         = k_q;
    j_d         = j_q;
    sub_d       = sub_q;
    row_d       = row_q;
    coil_d      = coil_q;
    base_d      = base_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      mfli_pkg::ST_IDLE: begin
        if (in_acc && (in_req == mfli_pkg::REQ_QUERY)) begin
          ph_d    = mfli_pkg::PH_AXIS;
          k_d     = '0;
          off_d   = '0;
          state_d = mfli_pkg::ST_OPND;
        end
      end
      mfli_pkg::ST_OPND: state_d = mfli_pkg::ST_MUL;
      mfli_pkg::ST_MUL:  state_d = mfli_pkg::ST_POST;
      mfli_pkg::ST_POST: begin
        state_d = mfli_pkg::ST_OPND;
        case (ph_q)
          mfli_pkg::PH_AXIS: state_d = mfli_pkg::ST_SP;
          mfli_pkg::PH_LERP: begin
            if (k_q != 2'd2) begin
              k_d = k_q + 2'd1;
            end else begin
              k_d   = '0;
              j_d   = '0;
              sub_d = '0;
              if (torque_q) begin
                ph_d = mfli_pkg::PH_TORQ;
              end else begin
                ph_d    = mfli_pkg::PH_GRAD;
                state_d = mfli_pkg::ST_RD0;
              end
            end
          end
          mfli_pkg::PH_TORQ: begin
            if (sub_q == 2'd0) begin
              sub_d = 2'd1;
            end else begin
              sub_d = '0;
              if (j_q != 2'd2) begin
                j_d = j_q + 2'd1;
              end else begin
                j_d     = '0;
                ph_d    = mfli_pkg::PH_GRAD;
                state_d = mfli_pkg::ST_RD0;
              end
            end
          end
          default: begin
            if (sub_q != 2'd2) begin
              sub_d = sub_q + 2'd1;
            end else begin
              sub_d = '0;
              if (k_q != 2'd2) begin
                k_d = k_q + 2'd1;
              end else begin
                k_d = '0;
                if (j_q != 2'd2) begin
                  j_d     = j_q + 2'd1;
                  state_d = mfli_pkg::ST_RD0;
                end else begin
                  row_d   = '0;
                  state_d = mfli_pkg::ST_EMIT;
                end
              end
            end
          end
        endcase
      end
      mfli_pkg::ST_SP: state_d = mfli_pkg::ST_FR;
      mfli_pkg::ST_FR: begin
        off_d = AW'(32'(off_q) * GRID_POINTS + 32'(fl));
        if (k_q != 2'd2) begin
          k_d     = k_q + 2'd1;
          state_d = mfli_pkg::ST_OPND;
        end else begin
          k_d     = '0;
          ph_d    = mfli_pkg::PH_LERP;
          coil_d  = '0;
          base_d  = '0;
          state_d = mfli_pkg::ST_RD0;
        end
      end
      mfli_pkg::ST_RD0: state_d = mfli_pkg::ST_RD1;
      mfli_pkg::ST_RD1: state_d = mfli_pkg::ST_RD2;
      mfli_pkg::ST_RD2: state_d = mfli_pkg::ST_OPND;
      mfli_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (row_q != mfli_pkg::ROW_LAST) begin
            row_d = row_q + 3'd1;
          end else if (coil_q == COL_LAST) begin
            state_d = mfli_pkg::ST_IDLE;
          end else begin
            coil_d  = coil_q + 3'd1;
            base_d  = base_q + CELLS_A;
            ph_d    = mfli_pkg::PH_LERP;
            k_d     = '0;
            j_d     = '0;
            state_d = mfli_pkg::ST_RD0;
          end
        end
      end
      default: state_d = mfli_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == mfli_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfli_pkg::ST_IDLE;
      ph_q        <= mfli_pkg::PH_AXIS;
      k_q         <= '0;
      j_q         <= '0;
      sub_q       <= '0;
      row_q       <= '0;
      coil_q      <= '0;
      base_q      <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
      irw_q       <= mfli_pkg::CFG_ONE;
      igs_q       <= mfli_pkg::CFG_ONE;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      k_q         <= k_d;
      j_q         <= j_d;
      sub_q       <= sub_d;
      row_q       <= row_d;
      coil_q      <= coil_d;
      base_q      <= base_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          mfli_pkg::CFG_IRW: irw_q <= cfg_wdata_i;
          mfli_pkg::CFG_IGS: igs_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_req == mfli_pkg::REQ_QUERY)) begin
      pos_q    <= in_vec;
      m_q      <= in_mag;
      torque_q <= in_torque;
    end
    if (state_q == mfli_pkg::ST_OPND && ph_q == mfli_pkg::PH_GRAD && sub_q == 2'd0) begin
      ga_q <= ga;
    end
    if (state_q == mfli_pkg::ST_RD1) begin
      if (ph_q == mfli_pkg::PH_GRAD) begin
        bi_q <= tbl_rdata;
      end else begin
        bf_q <= tbl_rdata;
      end
    end
    if (state_q == mfli_pkg::ST_RD2) begin
      if (ph_q == mfli_pkg::PH_GRAD) begin
        bj_q <= tbl_rdata;
      end else begin
        bc_q <= tbl_rdata;
      end
    end
    if (state_q == mfli_pkg::ST_SP) begin
      sp_q <= ({{8{s_q[31]}}, s_q} + 40'sd32768) * GM1_S;
    end
    if (state_q == mfli_pkg::ST_FR) begin
      r_q[k_q] <= mfli_pkg::sat32({{12{rdiff[39]}}, rdiff});
    end
    if (state_q == mfli_pkg::ST_POST) begin
      case (ph_q)
        mfli_pkg::PH_AXIS: s_q <= p_sat;
        mfli_pkg::PH_LERP: begin
          b_q[k_q]   <= mfli_pkg::sat32(mfli_pkg::ext52(bf_k) + mfli_pkg::ext52(p_sat));
          res_q[k_q] <= mfli_pkg::sat32(mfli_pkg::ext52(bf_k) + mfli_pkg::ext52(p_sat));
        end
        mfli_pkg::PH_TORQ: begin
          if (sub_q == 2'd0) begin
            acc_q <= p16;
          end else begin
            res_q[j_q] <= mfli_pkg::sat32(acc_q - p16);
          end
        end
        default: begin
          case (sub_q)
            2'd0: gg_q <= mfli_pkg::sat32(mfli_pkg::ext52(ga_q) + mfli_pkg::ext52(p_sat));
            2'd1: bd_q <= p_sat;
            default: begin
              acc_q <= acc_n;
              if (k_q == 2'd2) begin
                res_q[3'd3 + 3'(j_q)] <= mfli_pkg::sat32(acc_n);
              end
            end
          endcase
        end
      endcase
    end
    if (emit_go) begin
      out_row_q  <= row_q;
      out_col_q  <= coil_q;
      out_val_q  <= res_q[row_q];
      out_last_q <= (row_q == mfli_pkg::ROW_LAST) && (coil_q == COL_LAST);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_val_q, out_col_q, out_row_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- checks
  `MFLI_ASSERT_NOW(a_last_on_final, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, out_row_q == mfli_pkg::ROW_LAST && out_col_q == COL_LAST, "tlast away from final matrix entry")
  `MFLI_ASSERT_NEXT(a_busy_after_query, clk_i, rst_ni, in_acc && (in_req == mfli_pkg::REQ_QUERY), !s_axis_tready, "request taken while a query is in work")
  `MFLI_ASSERT_NOW(a_row_range, clk_i, rst_ni, m_axis_tvalid, out_row_q <= mfli_pkg::ROW_LAST, "matrix row out of range")

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int G = 16;
  localparam int COILS = 8;
  localparam int CELLS = G * G * G;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } entry_t;

  class matrix_scoreboard;
    int          bx[COILS*CELLS];
    int          by[COILS*CELLS];
    int          bz[COILS*CELLS];
    bit          loaded[COILS*CELLS];
    longint      irw;
    longint      igs;
    entry_t      expected_q[$];
    int          errors;

    function void reset_state();
      irw = 65536;
      igs = 65536;
      errors = 0;
    endfunction

    function void set_config(logic [0:0] idx, logic [30:0] val);
      if (idx == mfli_pkg::CFG_IRW) irw = val;
      else igs = val;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qm(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> 16;
    endfunction

    function int addr(int c, int x, int y, int z);
      return c * CELLS + (x * G + y) * G + z;
    endfunction

    function longint field(int k, int i);
      if (k == 0) return longint'(bx[i]);
      if (k == 1) return longint'(by[i]);
      return longint'(bz[i]);
    endfunction

    // floor cell and ratio of one axis
    function void axis(logic signed [31:0] pos, output int fl, output longint ratio);
      longint s;
      longint sp;
      longint f;
      s = sat(qm(longint'(pos), irw));
      sp = (s + 32768) * (G - 1);
      f = sp >>> 16;
      if (f > G - 2) f = G - 2;
      if (f < 0) f = 0;
      fl = int'(f);
      ratio = sat(sp - f * 65536);
    endfunction

    function bit cell_ready(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
      int     f[3];
      longint r;
      axis(px, f[0], r);
      axis(py, f[1], r);
      axis(pz, f[2], r);
      for (int c = 0; c < COILS; c++)
        for (int d = 0; d < 8; d++)
          if (!loaded[addr(c, f[0] + d[0], f[1] + d[1], f[2] + d[2])]) return 0;
      return 1;
    endfunction

    function void note_request(logic [0:0] req, logic [mfli_pkg::IN_DATA_W-1:0] d);
      logic signed [31:0] v[3];
      longint m[3];
      longint r[3];
      longint bf[3];
      longint bc[3];
      longint b[3];
      longint res[6];
      longint acc;
      longint a0;
      longint b0;
      longint e0;
      longint gg;
      int     fl[3];
      int     i;
      int     j;
      entry_t en;
      v[0] = d[46:15];
      v[1] = d[78:47];
      v[2] = d[110:79];
      if (req == mfli_pkg::REQ_LOAD) begin
        i = int'(d[2:0]) * CELLS + int'(d[14:3]);
        bx[i] = v[0];
        by[i] = v[1];
        bz[i] = v[2];
        loaded[i] = 1;
        return;
      end
      m[0] = longint'($signed(d[142:111]));
      m[1] = longint'($signed(d[174:143]));
      m[2] = longint'($signed(d[206:175]));
      for (int k = 0; k < 3; k++) axis(v[k], fl[k], r[k]);
      for (int c = 0; c < COILS; c++) begin
        for (int k = 0; k < 3; k++) begin
          bf[k] = field(k, addr(c, fl[0], fl[1], fl[2]));
          bc[k] = field(k, addr(c, fl[0] + 1, fl[1] + 1, fl[2] + 1));
          b[k] = sat(bf[k] + sat(qm(sat(bc[k] - bf[k]), r[k])));
        end
        if (d[207]) begin
          res[0] = sat(qm(m[1], b[2]) - qm(m[2], b[1]));
          res[1] = sat(qm(m[2], b[0]) - qm(m[0], b[2]));
          res[2] = sat(qm(m[0], b[1]) - qm(m[1], b[0]));
        end else begin
          for (int k = 0; k < 3; k++) res[k] = b[k];
        end
        // gradient along axis g: corner +g against the corner lacking only g
        for (int g = 0; g < 3; g++) begin
          acc = 0;
          i = addr(c, fl[0] + (g == 0), fl[1] + (g == 1), fl[2] + (g == 2));
          j = addr(c, fl[0] + (g != 0), fl[1] + (g != 1), fl[2] + (g != 2));
          for (int k = 0; k < 3; k++) begin
            a0 = sat(field(k, i) - bf[k]);
            b0 = sat(bc[k] - field(k, j));
            e0 = sat(b0 - a0);
            gg = sat(a0 + sat(qm(e0, r[k])));
            acc += qm(m[k], sat(qm(gg, igs)));
          end
          res[3 + g] = sat(acc);
        end
        for (int rw = 0; rw < 6; rw++) begin
          en.row = rw[2:0];
          en.col = c[2:0];
          en.value = res[rw][31:0];
          en.last = (c == COILS - 1) && (rw == 5);
          expected_q.push_back(en);
        end
      end
    endfunction

    function void check_result(logic [mfli_pkg::OUT_DATA_W-1:0] d, logic lst);
      entry_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected entry row %0d col %0d value %h last %b",
                 $time, d[2:0], d[5:3], d[37:6], lst);
        return;
      end
      e = expected_q.pop_front();
      if (d[2:0] !== e.row) begin
        errors++;
        $display("%0t: row exp %0d got %0d", $time, e.row, d[2:0]);
      end
      if (d[5:3] !== e.col) begin
        errors++;
        $display("%0t: col exp %0d got %0d", $time, e.col, d[5:3]);
      end
      if (d[37:6] !== e.value) begin
        errors++;
        $display("%0t: value (row %0d col %0d) exp %h got %h",
                 $time, e.row, e.col, e.value, d[37:6]);
      end
      if (lst !== e.last) begin
        errors++;
        $display("%0t: last exp %b got %b", $time, e.last, lst);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [mfli_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [mfli_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_we_i = 1'b0;
  logic [0:0]                      cfg_addr_i = '0;
  logic [mfli_pkg::CFG_W-1:0]      cfg_wdata_i = '0;

  matrix_scoreboard sb = new();
  bit burst = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;

  magnetic_field_lut_interpolator dut (.*);

  always #2 clk_i = ~clk_i;

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  function logic signed [31:0] rand_pos();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return $urandom;
    if (r == 1) return $signed($urandom_range(0, 80000)) - 40000;
    return rand_word();
  endfunction

  // monitors
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL magnetic_field_lut_interpolator");
      $finish;
    end
  end

  // receiver
  initial begin
    int n;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 0;
      end
      n = gap_len();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_request(logic [0:0] req, logic [mfli_pkg::IN_DATA_W-1:0] d);
    int n;
    n = gap_len();
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic load_point(int c, int gi, logic [31:0] fx, logic [31:0] fy,
                            logic [31:0] fz);
    send_request(mfli_pkg::REQ_LOAD, {1'($urandom), 96'({$urandom, $urandom, $urandom}),
                                      fz, fy, fx, gi[11:0], c[2:0]});
  endtask

  task automatic load_cell(int x, int y, int z);
    for (int c = 0; c < COILS; c++)
      for (int d = 0; d < 8; d++)
        load_point(c, ((x + d[0]) * G + y + d[1]) * G + z + d[2],
                   rand_word(), rand_word(), rand_word());
  endtask

  // positions whose cell is not fully loaded fall back to the centre cell
  task automatic query(logic signed [31:0] px, logic signed [31:0] py,
                       logic signed [31:0] pz, logic [31:0] mx, logic [31:0] my,
                       logic [31:0] mz, logic tq);
    if (!sb.cell_ready(px, py, pz)) begin
      px = 0;
      py = 0;
      pz = 0;
    end
    send_request(mfli_pkg::REQ_QUERY,
                 {tq, mz, my, mx, pz, py, px, 12'($urandom), 3'($urandom)});
  endtask

  task automatic random_query();
    logic signed [31:0] p[3];
    int tries;
    tries = 0;
    do begin
      p[0] = rand_pos();
      p[1] = rand_pos();
      p[2] = rand_pos();
      tries++;
    end while (!sb.cell_ready(p[0], p[1], p[2]) && tries < 100);
    query(p[0], p[1], p[2], rand_word(), rand_word(), rand_word(), 1'($urandom));
  endtask

  task automatic write_reg(logic [0:0] idx, logic [mfli_pkg::CFG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    // let the monitor note a request taken at the edge just passed
    @(posedge clk_i);
    while (sb.pending() != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    sb.set_config(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [mfli_pkg::CFG_W-1:0] irw_set[4];
    logic [mfli_pkg::CFG_W-1:0] igs_set[4];
    sb.reset_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lowest and highest corner cells plus the centre cell
    burst = 1;
    for (int d = 0; d < 8; d += 7)
      load_cell(d[0] ? G - 2 : 0, d[1] ? G - 2 : 0, d[2] ? G - 2 : 0);
    load_cell(7, 7, 7);
    burst = 0;

    // directed: grid extremes, centre, magnetization extremes, both modes
    query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 1'b0);
    query(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h80000000, 32'h80000000,
          32'h80000000, 1'b1);
    query(0, 0, 0, 32'h00010000, 32'hffff0000, 32'h0, 1'b0);
    query(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b1);
    query(32'sh00008000, -32'sh00008000, 32'sh7fffffff, 32'h80000000, 32'h0,
          32'h7fffffff, 1'b1);
    query(-32'sh00008000, 32'sh00007fff, 32'sh80000000, 32'h0, 32'h0, 32'h0, 1'b0);
    query(32'sh00001000, -32'sh00001000, 32'sh0, 32'h12345678, 32'h87654321,
          32'h00010000, 1'b1);

    irw_set = '{31'h7fffffff, 31'd0, 31'd65536, 31'($urandom)};
    igs_set = '{31'd0, 31'h7fffffff, 31'($urandom), 31'($urandom_range(1, 300000))};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(mfli_pkg::CFG_IRW, irw_set[ph]);
      write_reg(mfli_pkg::CFG_IGS, igs_set[ph]);
      if (ph == 1) hold_req = 1;
      for (int i = 0; i < 70; i++) begin
        burst = (i >= 40 && i < 50);
        if ($urandom_range(0, 2) == 0) random_query();
        else if ($urandom_range(0, 1) == 0)
          load_point($urandom_range(0, COILS - 1), $urandom_range(0, CELLS - 1),
                     rand_word(), rand_word(), rand_word());
        else
          load_point($urandom_range(0, COILS - 1),
                     (((G - 2) * $urandom_range(0, 1) + $urandom_range(0, 1)) * G
                      + (G - 2) * $urandom_range(0, 1) + $urandom_range(0, 1)) * G
                      + (G - 2) * $urandom_range(0, 1) + $urandom_range(0, 1),
                     rand_word(), rand_word(), rand_word());
      end
      burst = 0;
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS magnetic_field_lut_interpolator");
    end else begin
      $display("FAIL magnetic_field_lut_interpolator");
    end
    $finish;
  end

endmodule
